/* hdl/rfa_pkg.sv */
`timescale 1ns / 1ps

package rfa_pkg;

  // Internal arithmetic width; request and response fields stay 32 bits.
  localparam int DataWidth = 32;
  localparam int FieldWidth = 32;
  localparam int CntWidth = $clog2(DataWidth);

  typedef logic [DataWidth-1:0] word_t;

  typedef enum logic [2:0] {
    OP_ADD = 3'd0,
    OP_SUB = 3'd1,
    OP_MUL = 3'd2,
    OP_DIV = 3'd3,
    OP_NEG = 3'd4,
    OP_INC = 3'd5,
    OP_DEC = 3'd6
  } op_e;

  // Commands of the shared arithmetic unit.
  typedef enum logic [1:0] {
    CMD_MUL = 2'd0,
    CMD_DIV = 2'd1,
    CMD_ADD = 2'd2,
    CMD_SUB = 2'd3
  } cmd_e;

  typedef struct packed {
    logic [2:0]                   opcode;
    logic signed [FieldWidth-1:0] a_num;
    logic signed [FieldWidth-1:0] a_den;
    logic signed [FieldWidth-1:0] b_num;
    logic signed [FieldWidth-1:0] b_den;
  } req_t;

  typedef struct packed {
    logic signed [FieldWidth-1:0] res_num;
    logic signed [FieldWidth-1:0] res_den;
    logic                         zero_gcd_error;
  } rsp_t;

  typedef struct packed {
    logic  start;
    cmd_e  cmd;
    word_t a;
    word_t b;
  } unit_ctl_t;

  typedef struct packed {
    logic  done;
    word_t res;  // product, sum or quotient
    word_t rem;  // remainder of a divide
  } unit_rsp_t;

  // Sign-extend a 32-bit field, then cut to the data width.
  function automatic word_t from_field(logic [FieldWidth-1:0] f);
    logic signed [63:0] e;
    e = 64'($signed(f));
    return e[DataWidth-1:0];
  endfunction

  // Sign-extend a data word, then cut to the field width.
  function automatic logic [FieldWidth-1:0] to_field(word_t w);
    logic signed [63:0] e;
    e = 64'($signed(w));
    return e[FieldWidth-1:0];
  endfunction

endpackage

/* hdl/rfa_arith_unit.sv */
`timescale 1ns / 1ps

module rfa_arith_unit import rfa_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  unit_ctl_t ctl_i,
  output unit_rsp_t rsp_o
);

  typedef enum logic [7:0] {
    A_IDLE = 8'b0000_0001,
    A_ADD  = 8'b0000_0010,
    A_MUL  = 8'b0000_0100,
    A_ABSA = 8'b0000_1000,
    A_ABSB = 8'b0001_0000,
    A_DIV  = 8'b0010_0000,
    A_FIXQ = 8'b0100_0000,
    A_FIXR = 8'b1000_0000
  } astate_e;

  astate_e              state_q, state_d;
  logic                 done_q, done_d;
  cmd_e                 cmd_q, cmd_d;
  word_t                acc_q, acc_d;   // accumulator / partial remainder
  word_t                shq_q, shq_d;   // multiplier / dividend-quotient shifter
  word_t                opr_q, opr_d;   // multiplicand / divisor magnitude
  logic [CntWidth-1:0]  cnt_q, cnt_d;
  logic                 sa_q, sa_d, sb_q, sb_d, bz_q, bz_d;

  // The one adder/subtractor.
  word_t                opa, opb;
  logic                 sub;
  logic [DataWidth:0]   sum;
  word_t                rem_sh;
  logic                 last;

  assign rem_sh = {acc_q[DataWidth-2:0], shq_q[DataWidth-1]};
  assign last   = (cnt_q == CntWidth'(DataWidth - 1));
  assign sum    = {1'b0, opa} + {1'b0, opb ^ {DataWidth{sub}}} + (DataWidth+1)'(sub);

  always_comb begin
    opa = '0;
    opb = '0;
    sub = 1'b0;
    case (state_q)
      A_ADD: begin
        opa = shq_q;
        opb = opr_q;
        sub = sa_q;
      end
      A_MUL: begin
        opa = acc_q;
        opb = shq_q[0] ? opr_q : '0;
      end
      A_ABSA: begin
        opb = shq_q;
        sub = sa_q;
      end
      A_ABSB: begin
        opb = opr_q;
        sub = sb_q;
      end
      A_DIV: begin
        opa = rem_sh;
        opb = opr_q;
        sub = 1'b1;
      end
      A_FIXQ: begin
        opb = shq_q;
        sub = sa_q ^ sb_q;
      end
      A_FIXR: begin
        opb = acc_q;
        sub = sa_q;
      end
      default: ;
    endcase
  end

  always_comb begin
    state_d = state_q;
    done_d  = 1'b0;
    cmd_d   = cmd_q;
    acc_d   = acc_q;
    shq_d   = shq_q;
    opr_d   = opr_q;
    cnt_d   = cnt_q;
    sa_d    = sa_q;
    sb_d    = sb_q;
    bz_d    = bz_q;
    case (state_q)
      A_IDLE: begin
        if (ctl_i.start) begin
          cmd_d = ctl_i.cmd;
          acc_d = '0;
          shq_d = ctl_i.a;
          opr_d = ctl_i.b;
          cnt_d = '0;
          sa_d  = ctl_i.a[DataWidth-1];
          sb_d  = ctl_i.b[DataWidth-1];
          bz_d  = (ctl_i.b == '0);
          case (ctl_i.cmd)
            CMD_MUL: begin
              shq_d   = ctl_i.b;
              opr_d   = ctl_i.a;
              state_d = A_MUL;
            end
            CMD_DIV: state_d = A_ABSA;
            CMD_ADD: begin
              sa_d    = 1'b0;
              state_d = A_ADD;
            end
            CMD_SUB: begin
              sa_d    = 1'b1;
              state_d = A_ADD;
            end
            default: state_d = A_IDLE;
          endcase
        end
      end
      A_ADD: begin
        acc_d   = sum[DataWidth-1:0];
        done_d  = 1'b1;
        state_d = A_IDLE;
      end
      A_MUL: begin
        // shift-add, low word only
        acc_d = sum[DataWidth-1:0];
        opr_d = {opr_q[DataWidth-2:0], 1'b0};
        shq_d = {1'b0, shq_q[DataWidth-1:1]};
        cnt_d = cnt_q + 1'b1;
        if (last) begin
          done_d  = 1'b1;
          state_d = A_IDLE;
        end
      end
      A_ABSA: begin
        shq_d   = sum[DataWidth-1:0];
        state_d = A_ABSB;
      end
      A_ABSB: begin
        opr_d   = sum[DataWidth-1:0];
        state_d = A_DIV;
      end
      A_DIV: begin
        // restoring step: carry out means the trial subtract fits
        acc_d = sum[DataWidth] ? sum[DataWidth-1:0] : rem_sh;
        shq_d = {shq_q[DataWidth-2:0], sum[DataWidth]};
        cnt_d = cnt_q + 1'b1;
        if (last) state_d = A_FIXQ;
      end
      A_FIXQ: begin
        shq_d   = bz_q ? '0 : sum[DataWidth-1:0];
        state_d = A_FIXR;
      end
      A_FIXR: begin
        acc_d   = bz_q ? '0 : sum[DataWidth-1:0];
        done_d  = 1'b1;
        state_d = A_IDLE;
      end
      default: state_d = A_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= A_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
    acc_q <= acc_d;
    shq_q <= shq_d;
    opr_q <= opr_d;
    cnt_q <= cnt_d;
    sa_q  <= sa_d;
    sb_q  <= sb_d;
    bz_q  <= bz_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.res  = (cmd_q == CMD_DIV) ? shq_q : acc_q;
  assign rsp_o.rem  = acc_q;

endmodule

/* hdl/rational_fraction_alu_core.sv */
`timescale 1ns / 1ps

// Channel   Direction  Handshake                 Payload
// request   in         in_valid_i / in_stall_o   in_req_i  (req_t)
// response  out        out_valid_o / out_stall_i out_rsp_o (rsp_t)
//
// One request at a time; in_stall_o is high from accept until the result moves to the
// output register. All math shares one add/shift unit (multiply, divide, add,
// subtract); increment/decrement use one divide per Euclid remainder step.
// Reset (async, active low) clears the sequencer and valids; a response held by
// out_stall_i delays only the next hand-off, not the accept.

module rational_fraction_alu_core import rfa_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  req_t in_req_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output rsp_t out_rsp_o
);

  // Sequencer states.
  typedef enum logic [8:0] {
    ST_IDLE = 9'b0_0000_0001,
    ST_M1   = 9'b0_0000_0010,  // first cross product
    ST_M2   = 9'b0_0000_0100,  // denominator product
    ST_M3   = 9'b0_0000_1000,  // second cross product (add/sub)
    ST_ADD  = 9'b0_0001_0000,  // combine / negate / step
    ST_GCD  = 9'b0_0010_0000,  // Euclid remainder loop
    ST_QN   = 9'b0_0100_0000,  // numerator / gcd
    ST_QD   = 9'b0_1000_0000,  // denominator / gcd
    ST_OUT  = 9'b1_0000_0000   // hand off to output register
  } state_e;

  state_e     state_q, state_d;
  logic       pend_q, pend_d;      // unit command in flight
  logic       out_valid_q, out_valid_d;
  rsp_t       out_q, out_d;

  logic [2:0] op_q, op_d;
  word_t      an_q, an_d, ad_q, ad_d, bn_q, bn_d, bd_q, bd_d;
  word_t      rn_q, rn_d, rd_q, rd_d;
  word_t      t_q, t_d;            // scratch: second product, then Euclid x / gcd
  word_t      y_q, y_d;            // Euclid y
  logic       err_q, err_d;

  unit_ctl_t  ctl;
  unit_rsp_t  ursp;
  logic       use_unit;
  logic       is_addsub, is_incdec;

  assign is_addsub = (op_q == OP_ADD) || (op_q == OP_SUB);
  assign is_incdec = (op_q == OP_INC) || (op_q == OP_DEC);

  rfa_arith_unit u_arith (
    .clk_i,
    .rst_ni,
    .ctl_i (ctl),
    .rsp_o (ursp)
  );

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    an_d        = an_q;
    ad_d        = ad_q;
    bn_d        = bn_q;
    bd_d        = bd_q;
    rn_d        = rn_q;
    rd_d        = rd_q;
    t_d         = t_q;
    y_d         = y_q;
    err_d       = err_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    use_unit    = 1'b0;
    ctl.cmd     = CMD_MUL;
    ctl.a       = an_q;
    ctl.b       = bd_q;

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          op_d  = in_req_i.opcode;
          an_d  = from_field(in_req_i.a_num);
          ad_d  = from_field(in_req_i.a_den);
          bn_d  = from_field(in_req_i.b_num);
          bd_d  = from_field(in_req_i.b_den);
          rn_d  = from_field(in_req_i.a_num);
          rd_d  = from_field(in_req_i.a_den);
          err_d = 1'b0;
          case (in_req_i.opcode)
            OP_ADD, OP_SUB, OP_MUL, OP_DIV: state_d = ST_M1;
            OP_NEG, OP_INC, OP_DEC:         state_d = ST_ADD;
            default:                        state_d = ST_OUT;  // A passes through
          endcase
        end
      end
      ST_M1: begin
        use_unit = 1'b1;
        ctl.a    = an_q;
        ctl.b    = (op_q == OP_MUL) ? bn_q : bd_q;
        if (ursp.done) begin
          rn_d    = ursp.res;
          state_d = ST_M2;
        end
      end
      ST_M2: begin
        use_unit = 1'b1;
        ctl.a    = ad_q;
        ctl.b    = (op_q == OP_DIV) ? bn_q : bd_q;
        if (ursp.done) begin
          rd_d    = ursp.res;
          state_d = is_addsub ? ST_M3 : ST_OUT;
        end
      end
      ST_M3: begin
        use_unit = 1'b1;
        ctl.a    = bn_q;
        ctl.b    = ad_q;
        if (ursp.done) begin
          t_d     = ursp.res;
          state_d = ST_ADD;
        end
      end
      ST_ADD: begin
        use_unit = 1'b1;
        ctl.cmd  = ((op_q == OP_ADD) || (op_q == OP_INC)) ? CMD_ADD : CMD_SUB;
        if (is_addsub) begin
          ctl.a = rn_q;
          ctl.b = t_q;
        end else if (op_q == OP_NEG) begin
          ctl.a = '0;
          ctl.b = an_q;
        end else begin
          ctl.a = an_q;
          ctl.b = ad_q;
        end
        if (ursp.done) begin
          rn_d = ursp.res;
          t_d  = ursp.res;
          y_d  = ad_q;
          state_d = is_incdec ? ST_GCD : ST_OUT;
        end
      end
      ST_GCD: begin
        ctl.cmd = CMD_DIV;
        ctl.a   = t_q;
        ctl.b   = y_q;
        if (y_q == '0) begin
          // x is the gcd; a zero gcd leaves the parts unreduced
          if (t_q == '0) begin
            err_d   = 1'b1;
            state_d = ST_OUT;
          end else begin
            state_d = ST_QN;
          end
        end else begin
          use_unit = 1'b1;
          if (ursp.done) begin
            t_d = y_q;
            y_d = ursp.rem;
          end
        end
      end
      ST_QN: begin
        use_unit = 1'b1;
        ctl.cmd  = CMD_DIV;
        ctl.a    = rn_q;
        ctl.b    = t_q;
        if (ursp.done) begin
          rn_d    = ursp.res;
          state_d = ST_QD;
        end
      end
      ST_QD: begin
        use_unit = 1'b1;
        ctl.cmd  = CMD_DIV;
        ctl.a    = rd_q;
        ctl.b    = t_q;
        if (ursp.done) begin
          rd_d    = ursp.res;
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_d.res_num        = to_field(rn_q);
          out_d.res_den        = to_field(rd_q);
          out_d.zero_gcd_error = err_q;
          out_valid_d          = 1'b1;
          state_d              = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase

    // one command per unit pass; done closes it
    ctl.start = use_unit && !pend_q;
    if (ursp.done)      pend_d = 1'b0;
    else if (ctl.start) pend_d = 1'b1;
    else                pend_d = pend_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q  <= op_d;
    an_q  <= an_d;
    ad_q  <= ad_d;
    bn_q  <= bn_d;
    bd_q  <= bd_d;
    rn_q  <= rn_d;
    rd_q  <= rd_d;
    t_q   <= t_d;
    y_q   <= y_d;
    err_q <= err_d;
    out_q <= out_d;
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

endmodule

/* hdl/rfa_checker.sv */
`timescale 1ns / 1ps

module rfa_checker import rfa_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_stall_o,
  input req_t in_req_i,
  input logic out_valid_o,
  input logic out_stall_i,
  input rsp_t out_rsp_o
);

  // held response stays offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("response dropped while stalled");

  // held response keeps its value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_rsp_o))
    else $error("stalled response changed");

  // an accepted request always makes the sequencer busy in the following cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("request accepted back to back");

  // zero gcd only arises when both parts are zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_rsp_o.zero_gcd_error |->
      (out_rsp_o.res_num == '0) && (out_rsp_o.res_den == '0))
    else $error("zero gcd flag with nonzero parts");

endmodule

bind rational_fraction_alu_core rfa_checker u_rfa_checker (.*);
